// File: rtl/h263s_pkg.sv
// Shared types, widths and constants of the H.263 RTP packet splitter.
package h263s_pkg;

    localparam int C_WINDOW_BYTES    = 2048;
    localparam int C_FRAME_MAX_BYTES = 1048576;

    localparam int C_MAXPL_W  = 11;
    localparam int C_CUT_W    = 11;
    localparam int C_OFF_W    = 12;
    localparam int C_OUT_OFF_W = 20;

    localparam logic [C_MAXPL_W-1:0] C_MAXPL_RESET = 11'd1400;
    localparam logic [C_MAXPL_W-1:0] C_MAXPL_MIN   = 11'd8;

    localparam logic [7:0] C_FMT_MASK = 8'h1c;
    localparam logic [7:0] C_INTER    = 8'h10;
    localparam logic [7:0] C_PBIT     = 8'h04;

    localparam logic [2:0] C_HLEN_MODE_A = 3'd4;
    localparam logic [2:0] C_HLEN_PLUS   = 3'd2;

    localparam logic C_REG_CODEC_MODE  = 1'b0;
    localparam logic C_REG_MAX_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0]           data_byte;
        logic                 frame_end;
        logic                 first;
        logic                 mode;
        logic [C_MAXPL_W-1:0] maxpl;
        logic                 key;
        logic [2:0]           fmt;
    } t_entry;

endpackage

// File: rtl/h263_rtp_packet_splitter_top.sv
// Top level of the H.263 RTP packet splitter with its register port.
//
// Frame bytes enter one per request and leave as packet descriptors. Each
// byte passes through the packet builder as a queue pop plus a two-byte
// look at the window head through the single window read port; a two-entry
// queue in front takes new bytes meanwhile. When a packet is cut before the
// frame end, the backward start-code scan reads four window bytes per
// two-byte step, once per packet. Each descriptor then waits in the output
// register until taken. The window memory needs no clearing.
module h263_rtp_packet_splitter_top #(
    parameter int WINDOW_BYTES    = h263s_pkg::C_WINDOW_BYTES,
    parameter int FRAME_MAX_BYTES = h263s_pkg::C_FRAME_MAX_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tlast,   // frame_end
    input  logic        i_s_tuser,   // key_frame
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // header_len, header_byte0, header_byte1,
                                     // payload_offset, payload_len, zero fill
    output logic        o_m_tlast,   // marker
    output logic [1:0]  o_m_tuser    // key_first, run_last
);
    import h263s_pkg::*;

    logic                 r_codec_mode;
    logic [C_MAXPL_W-1:0] r_max_payload;
    t_entry               w_q;
    logic                 w_q_valid;
    logic                 w_q_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode  <= 1'b0;
            r_max_payload <= C_MAXPL_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                C_REG_CODEC_MODE:  r_codec_mode  <= pwdata[0];
                C_REG_MAX_PAYLOAD: r_max_payload <= pwdata[C_MAXPL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            C_REG_CODEC_MODE:  prdata = {31'b0, r_codec_mode};
            C_REG_MAX_PAYLOAD: prdata = {21'b0, r_max_payload};
            default:           prdata = '0;
        endcase
    end

    h263s_front #(
        .FRAME_MAX_BYTES(FRAME_MAX_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_s_tuser    (i_s_tuser),
        .i_codec_mode (r_codec_mode),
        .i_max_payload(r_max_payload),
        .o_q          (w_q),
        .o_q_valid    (w_q_valid),
        .i_q_ready    (w_q_ready)
    );

    h263s_back #(
        .WINDOW_BYTES   (WINDOW_BYTES),
        .FRAME_MAX_BYTES(FRAME_MAX_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (w_q),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

endmodule

// File: rtl/h263s_front.sv
// Input side: frame tracking, per-byte classification and a two-entry request queue.
module h263s_front #(
    parameter int FRAME_MAX_BYTES = h263s_pkg::C_FRAME_MAX_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,
    input  logic                              i_s_tlast,
    input  logic                              i_s_tuser,
    input  logic                              i_codec_mode,
    input  logic [h263s_pkg::C_MAXPL_W-1:0]   i_max_payload,
    output h263s_pkg::t_entry                 o_q,
    output logic                              o_q_valid,
    input  logic                              i_q_ready
);
    import h263s_pkg::*;

    localparam int FW = $clog2(FRAME_MAX_BYTES);

    logic                 r_in_frame;
    logic [FW-1:0]        r_foff;
    logic [2:0]           r_fmt;
    logic                 r_mode;
    logic [C_MAXPL_W-1:0] r_maxpl;
    logic                 r_key;
    t_entry               r_q [2];
    logic                 r_wp;
    logic                 r_rp;
    logic [1:0]           r_cnt;

    logic          w_acc;
    logic          w_pop;
    logic          w_first;
    logic [FW-1:0] w_foff;
    logic [2:0]    w_fmt;
    t_entry        w_ent;

    assign w_acc   = i_s_tvalid && o_s_tready;
    assign w_pop   = o_q_valid && i_q_ready;
    assign w_first = !r_in_frame;
    assign w_foff  = w_first ? '0 : r_foff;

    always_comb begin
        w_fmt = w_first ? 3'd0 : r_fmt;
        if (w_foff == FW'(4)) begin
            w_fmt = 3'((i_s_tdata & C_FMT_MASK) >> 2);
        end
        w_ent.data_byte = i_s_tdata;
        w_ent.frame_end = i_s_tlast;
        w_ent.first     = w_first;
        w_ent.mode      = w_first ? i_codec_mode : r_mode;
        w_ent.maxpl     = w_first ? i_max_payload : r_maxpl;
        w_ent.key       = w_first ? i_s_tuser : r_key;
        w_ent.fmt       = w_fmt;
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_foff     <= '0;
            r_fmt      <= '0;
            r_mode     <= 1'b0;
            r_maxpl    <= C_MAXPL_RESET;
            r_key      <= 1'b0;
            r_wp       <= 1'b0;
            r_rp       <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (w_acc) begin
                r_q[r_wp]  <= w_ent;
                r_wp       <= !r_wp;
                r_in_frame <= !i_s_tlast;
                r_fmt      <= w_fmt;
                r_mode     <= w_ent.mode;
                r_maxpl    <= w_ent.maxpl;
                r_key      <= w_ent.key;
                if (i_s_tlast || w_foff == FW'(FRAME_MAX_BYTES - 1)) begin
                    r_foff <= '0;
                end else begin
                    r_foff <= w_foff + 1'b1;
                end
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_acc} - {1'b0, w_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> r_cnt == 2'd2) else $error("queue overfilled");
    a_first_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_s_tlast) |=> !r_in_frame) else $error("frame not closed");

endmodule

// File: rtl/h263s_back.sv
// Packet builder: byte window, start-code scan and descriptor output register.
module h263s_back #(
    parameter int WINDOW_BYTES    = h263s_pkg::C_WINDOW_BYTES,
    parameter int FRAME_MAX_BYTES = h263s_pkg::C_FRAME_MAX_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  h263s_pkg::t_entry i_q,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [55:0]       o_m_tdata,  // header_len, header_byte0, header_byte1,
                                          // payload_offset, payload_len, zero fill
    output logic              o_m_tlast,  // marker
    output logic [1:0]        o_m_tuser   // key_first, run_last
);
    import h263s_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int HW = $clog2(WINDOW_BYTES + 1);
    localparam int FW = $clog2(FRAME_MAX_BYTES);
    localparam int EW = ((HW > C_OFF_W) ? HW : C_OFF_W) + 2;
    localparam int CAP_LIM = WINDOW_BYTES - 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PEEK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [7:0]           r_mem [WINDOW_BYTES];
    logic [7:0]           r_rd_data;
    logic                 r_rd_ok;
    logic [2:0]           r_state;
    logic [2:0]           r_sub;
    logic [HW-1:0]        r_held;
    logic [AW-1:0]        r_base;
    logic [FW-1:0]        r_pstart;
    logic                 r_first_pend;
    logic                 r_mode;
    logic [C_MAXPL_W-1:0] r_maxpl;
    logic                 r_key;
    logic [2:0]           r_fmt;
    logic                 r_final;
    logic [1:0]           r_n;
    logic                 r_skip;
    logic [C_CUT_W-1:0]   r_i;
    logic [C_CUT_W-1:0]   r_cut;
    logic                 r_z0;
    logic                 r_zp1;
    logic                 r_zp2;
    logic                 r_ovalid;
    logic [55:0]          r_odata;
    logic                 r_olast;
    logic [1:0]           r_ouser;

    logic [C_MAXPL_W-1:0] w_m;
    logic [2:0]           w_hlen;
    logic [C_MAXPL_W-1:0] w_capraw;
    logic [C_CUT_W-1:0]   w_cap;
    logic [C_OFF_W-1:0]   w_rd_off;
    logic [EW-1:0]        w_rsum;
    logic [AW-1:0]        w_raddr;
    logic [EW-1:0]        w_wsum;
    logic [AW-1:0]        w_waddr;
    logic                 w_wr;
    logic                 w_rz;
    logic                 w_skipc;
    logic [EW-1:0]        w_availc;
    logic [EW-1:0]        w_used;
    logic [HW-1:0]        w_held_after;
    logic [EW-1:0]        w_bsum;
    logic [FW:0]          w_psum;
    logic [FW:0]          w_osum;
    logic [FW-1:0]        w_poff;
    logic [EW-1:0]        w_need;
    logic [7:0]           w_hb0;
    logic [7:0]           w_hb1;

    always_comb begin
        w_m      = (r_maxpl < C_MAXPL_MIN) ? C_MAXPL_MIN : r_maxpl;
        w_hlen   = r_mode ? C_HLEN_PLUS : C_HLEN_MODE_A;
        w_capraw = w_m - C_MAXPL_W'(w_hlen);
        w_cap    = (32'(w_capraw) > 32'(CAP_LIM)) ? C_CUT_W'(CAP_LIM) : w_capraw;
    end

    always_comb begin
        if (r_state == S_SCAN) begin
            w_rd_off = C_OFF_W'({r_skip, 1'b0}) + C_OFF_W'(r_i) + C_OFF_W'(2)
                       - C_OFF_W'(r_sub);
        end else begin
            w_rd_off = (r_sub == 3'd0) ? '0 : C_OFF_W'(1);
        end
        w_rsum = EW'(r_base) + EW'(w_rd_off);
        if (w_rsum >= EW'(WINDOW_BYTES)) begin
            w_raddr = AW'(w_rsum - EW'(WINDOW_BYTES));
        end else begin
            w_raddr = AW'(w_rsum);
        end
        w_wsum = EW'(r_base) + EW'(i_q.first ? '0 : r_held);
        if (w_wsum >= EW'(WINDOW_BYTES)) begin
            w_waddr = AW'(w_wsum - EW'(WINDOW_BYTES));
        end else begin
            w_waddr = AW'(w_wsum);
        end
    end

    assign o_q_ready = (r_state == S_IDLE);
    assign w_wr      = i_q_valid && o_q_ready
                       && (i_q.first || r_held < HW'(WINDOW_BYTES));
    assign w_rz      = r_rd_ok && (r_rd_data == 8'd0);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr] <= i_q.data_byte;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_comb begin
        w_skipc  = r_mode && r_z0 && w_rz;
        w_need   = EW'({w_skipc, 1'b0}) + EW'(w_cap) + EW'(2);
        w_availc = (EW'(r_held) >= EW'({w_skipc, 1'b0}))
                   ? EW'(r_held) - EW'({w_skipc, 1'b0}) : '0;
        w_used   = EW'({r_skip, 1'b0}) + EW'(r_cut);
        if (w_used > EW'(r_held)) begin
            w_used = EW'(r_held);
        end
        w_held_after = r_held - HW'(w_used);
        w_bsum = EW'(r_base) + w_used;
        w_psum = (FW+1)'(r_pstart) + (FW+1)'(w_used);
        w_osum = (FW+1)'(r_pstart) + (FW+1)'({r_skip, 1'b0});
        w_poff = (w_osum >= (FW+1)'(FRAME_MAX_BYTES))
                 ? FW'(w_osum - (FW+1)'(FRAME_MAX_BYTES)) : FW'(w_osum);
        w_hb0  = r_skip ? C_PBIT : 8'h00;
        w_hb1  = r_mode ? 8'h00 : ({r_fmt, 5'b0} | (r_key ? 8'h00 : C_INTER));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sub        <= '0;
            r_held       <= '0;
            r_base       <= '0;
            r_pstart     <= '0;
            r_first_pend <= 1'b1;
            r_mode       <= 1'b0;
            r_maxpl      <= C_MAXPL_RESET;
            r_key        <= 1'b0;
            r_fmt        <= '0;
            r_final      <= 1'b0;
            r_n          <= '0;
            r_skip       <= 1'b0;
            r_ovalid     <= 1'b0;
            r_rd_ok      <= 1'b0;
        end else begin
            r_rd_ok <= (EW'(w_rd_off) < EW'(r_held));
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q.first) begin
                            r_held       <= HW'(1);
                            r_pstart     <= '0;
                            r_first_pend <= 1'b1;
                        end else if (r_held < HW'(WINDOW_BYTES)) begin
                            r_held <= r_held + 1'b1;
                        end
                        r_mode  <= i_q.mode;
                        r_maxpl <= i_q.maxpl;
                        r_key   <= i_q.key;
                        r_fmt   <= i_q.fmt;
                        r_final <= i_q.frame_end;
                        r_n     <= '0;
                        r_sub   <= '0;
                        r_state <= S_PEEK;
                    end
                end
                S_PEEK: begin
                    if (r_sub == 3'd0) begin
                        r_sub <= 3'd1;
                    end else if (r_sub == 3'd1) begin
                        r_z0  <= w_rz;
                        r_sub <= 3'd2;
                    end else begin
                        r_skip <= w_skipc;
                        r_sub  <= '0;
                        if (r_final && (r_held == '0 || r_n == 2'd3)) begin
                            r_held       <= '0;
                            r_pstart     <= '0;
                            r_first_pend <= 1'b1;
                            r_state      <= S_IDLE;
                        end else if (!r_final && EW'(r_held) < w_need) begin
                            r_state <= S_IDLE;
                        end else if (w_availc > EW'(w_cap)) begin
                            r_i     <= w_cap - 1'b1;
                            r_cut   <= w_cap;
                            r_state <= S_SCAN;
                        end else begin
                            r_cut   <= C_CUT_W'(w_availc);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_sub <= r_sub + 1'b1;
                    if (r_sub == 3'd1) begin
                        r_zp2 <= w_rz;
                    end
                    if (r_sub == 3'd2) begin
                        r_zp1 <= w_rz;
                    end
                    if (r_sub == 3'd3) begin
                        r_z0 <= w_rz;
                    end
                    if (r_sub == 3'd4) begin
                        r_sub <= '0;
                        if (r_z0 && r_zp1 && !r_zp2) begin
                            r_cut   <= r_i;
                            r_state <= S_DONE;
                        end else if (r_z0 && w_rz && !r_zp1) begin
                            r_cut   <= r_i - 1'b1;
                            r_state <= S_DONE;
                        end else if (r_i <= C_CUT_W'(3)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i <= r_i - C_CUT_W'(2);
                        end
                    end
                end
                S_DONE: begin
                    r_odata <= {6'b0, r_cut, C_OUT_OFF_W'(w_poff), w_hb1, w_hb0, w_hlen};
                    r_olast <= r_final && (w_held_after == '0);
                    r_ouser <= {!r_final || w_held_after == '0 || r_n == 2'd2,
                                r_key && r_first_pend};
                    r_ovalid     <= 1'b1;
                    r_held       <= w_held_after;
                    r_base       <= (w_bsum >= EW'(WINDOW_BYTES))
                                    ? AW'(w_bsum - EW'(WINDOW_BYTES)) : AW'(w_bsum);
                    r_pstart     <= (w_psum >= (FW+1)'(FRAME_MAX_BYTES))
                                    ? FW'(w_psum - (FW+1)'(FRAME_MAX_BYTES)) : FW'(w_psum);
                    r_first_pend <= 1'b0;
                    r_n          <= r_n + 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_sub   <= '0;
                        r_state <= r_final ? S_PEEK : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == S_OUT) else $error("descriptor outside output state");
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HW'(WINDOW_BYTES)) else $error("window overfilled");
    a_sub_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_sub <= 3'd4) else $error("scan step out of range");
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_n != 2'd3) else $error("too many packets for one byte");

endmodule
